[rtl/tla_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tla_pkg;
    localparam int NodeW  = 10;
    localparam int Nodes  = 1 << NodeW;
    localparam int LinkW  = 12;
    localparam int EdgeAw = 11;
    localparam int Edges  = 1 << EdgeAw;
    localparam int DepthW = 11;
    localparam int Levels = 10;
    localparam int LevelW = 4;
    localparam int JumpAw = NodeW + LevelW;

    localparam logic [1:0] REQ_EDGE  = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_UNBUILT   = 2'd2;
    localparam logic [1:0] ST_UNREACHED = 2'd3;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE,
        S_E_RD, S_E_WAIT, S_E_W1, S_E_W2,
        S_B_CLR, S_B_INIT, S_B_ROOTJ, S_B_POP, S_B_POPW, S_B_HEAD, S_B_HEADW, S_B_LINK,
        S_B_LINKW, S_B_CHILD, S_B_CHILDW, S_B_RCHK, S_B_JREQ, S_B_JW1, S_B_JREQ2, S_B_JW2,
        S_B_JWR, S_B_NEXT,
        S_Q_DEP, S_Q_RA, S_Q_RB, S_Q_DEPW, S_Q_L1, S_Q_L1W, S_Q_L1D, S_Q_L1DW, S_Q_L1C,
        S_Q_L2A, S_Q_L2AW, S_Q_L2B, S_Q_L2BW, S_Q_FIN, S_Q_FINW,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

[rtl/tla_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module tla_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/tree_lca_binary_lifting_core.sv]
// tree lca engine, binary lifting
// input beat: s_req_type, s_node_a, s_node_b on s_valid/s_ready
// output beat: m_ancestor, m_status on m_valid/m_ready, one per input beat
// root_node written through cfg_we/cfg_wdata (reset value 1); the user
// writes it only while idle, the block does not enforce this
// one item at a time, sequenced over shared rams with registered reads
// an edge stores a->b then b->a; type 3 and rejected edges go straight to
// the result, a failed query stops at its first failed check
// query: check and load depths, lift a level by level, then jump both
// together level by level, which is skipped when one node is above the other
// build: clear reached flags, seed the root, walk each reached node's adjacency
// list, writing a jump row for each newly reached node
// after reset a clearing pass zeroes the adjacency heads, s_ready low meanwhile
// result is held in an output register until m_ready; s_ready is low
// while a result waits, the next beat is taken the cycle after m_ready
`timescale 1ns / 1ps
`default_nettype none
module tree_lca_binary_lifting_core
    import tla_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [9:0]  s_node_a,
    input  wire logic [9:0]  s_node_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [9:0]       m_ancestor,
    output logic [1:0]       m_status,
    input  wire logic        cfg_we,
    input  wire logic [9:0]  cfg_wdata
);
    state_t state_reg, state_next;
    logic [NodeW-1:0] root_reg;
    logic [1:0] req_reg, req_next;
    logic [NodeW-1:0] a_reg, a_next, b_reg, b_next, t_reg, t_next, j_reg, j_next, p_reg, p_next;
    logic [LinkW-1:0] ecnt_reg, ecnt_next, link_reg, link_next;
    logic [NodeW:0] qh_reg, qh_next, qt_reg, qt_next;
    logic [LevelW-1:0] k_reg, k_next;
    logic [DepthW-1:0] da_reg, da_next, db_reg, db_next, dt_reg, dt_next;
    logic built_reg, built_next;
    logic [NodeW-1:0] anc_reg, anc_next;
    logic [1:0] st_reg, st_next;
    logic [NodeW:0] clr_reg, clr_next;

    // head ram
    logic h_we; logic [NodeW-1:0] h_wa, h_ra; logic [LinkW-1:0] h_wd, h_rd;
    tla_ram #(.Width(LinkW), .Depth(Nodes)) u_head (.aclk, .we(h_we), .waddr(h_wa),
        .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    // edge ram: next link + target
    logic e_we; logic [EdgeAw-1:0] e_wa, e_ra; logic [LinkW+NodeW-1:0] e_wd, e_rd;
    tla_ram #(.Width(LinkW+NodeW), .Depth(Edges)) u_edge (.aclk, .we(e_we), .waddr(e_wa),
        .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
    // depth ram
    logic d_we; logic [NodeW-1:0] d_wa, d_ra; logic [DepthW-1:0] d_wd, d_rd;
    tla_ram #(.Width(DepthW), .Depth(Nodes)) u_dep (.aclk, .we(d_we), .waddr(d_wa),
        .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
    // jump ram, addr {node, level}
    logic j_we; logic [JumpAw-1:0] j_wa, j_ra; logic [NodeW-1:0] j_wd, j_rd;
    tla_ram #(.Width(NodeW), .Depth(1 << JumpAw)) u_jump (.aclk, .we(j_we), .waddr(j_wa),
        .wdata(j_wd), .raddr(j_ra), .rdata(j_rd));
    // queue ram
    logic q_we; logic [NodeW-1:0] q_wa, q_ra; logic [NodeW-1:0] q_wd, q_rd;
    tla_ram #(.Width(NodeW), .Depth(Nodes)) u_q (.aclk, .we(q_we), .waddr(q_wa),
        .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
    // reached flags
    logic r_we; logic [NodeW-1:0] r_wa, r_ra; logic r_wd, r_rd;
    tla_ram #(.Width(1), .Depth(Nodes)) u_reach (.aclk, .we(r_we), .waddr(r_wa),
        .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));

    logic cfg_root_bad;
    assign cfg_root_bad = (root_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            root_reg <= NodeW'(1);
            ecnt_reg <= '0;
            built_reg <= 1'b0;
            clr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) root_reg <= cfg_wdata;
            ecnt_reg <= ecnt_next;
            built_reg <= built_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next; a_reg <= a_next; b_reg <= b_next; t_reg <= t_next;
        j_reg <= j_next; p_reg <= p_next; link_reg <= link_next; qh_reg <= qh_next;
        qt_reg <= qt_next; k_reg <= k_next; da_reg <= da_next; db_reg <= db_next;
        dt_reg <= dt_next; anc_reg <= anc_next; st_reg <= st_next;
    end

    always_comb begin
        state_next = state_reg;
        req_next = req_reg; a_next = a_reg; b_next = b_reg; t_next = t_reg;
        j_next = j_reg; p_next = p_reg; link_next = link_reg; qh_next = qh_reg;
        qt_next = qt_reg; k_next = k_reg; da_next = da_reg; db_next = db_reg;
        dt_next = dt_reg; anc_next = anc_reg; st_next = st_reg;
        ecnt_next = ecnt_reg; built_next = built_reg; clr_next = clr_reg;
        h_we = 1'b0; h_wa = a_reg; h_wd = ecnt_reg; h_ra = a_reg;
        e_we = 1'b0; e_wa = ecnt_reg[EdgeAw-1:0]; e_wd = {h_rd, b_reg};
        e_ra = EdgeAw'(link_reg - LinkW'(1));
        d_we = 1'b0; d_wa = j_reg; d_wd = dt_reg + DepthW'(1); d_ra = a_reg;
        j_we = 1'b0; j_wa = {j_reg, k_reg}; j_wd = t_reg; j_ra = {a_reg, k_reg};
        q_we = 1'b0; q_wa = qt_reg[NodeW-1:0]; q_wd = j_reg; q_ra = qh_reg[NodeW-1:0];
        r_we = 1'b0; r_wa = j_reg; r_wd = 1'b1; r_ra = a_reg;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                h_we = 1'b1; h_wa = clr_reg[NodeW-1:0]; h_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (NodeW+1)'(Nodes - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next = s_req_type; a_next = s_node_a; b_next = s_node_b;
                    anc_next = '0; st_next = ST_OK; clr_next = '0;
                    case (s_req_type)
                        REQ_EDGE: state_next = (s_node_a != '0 && s_node_b != '0)
                            ? ((ecnt_reg + LinkW'(2) > LinkW'(Edges)) ? S_OUT : S_E_RD)
                            : S_OUT;
                        REQ_BUILD: state_next = S_B_CLR;
                        REQ_QUERY: state_next = S_Q_DEP;
                        default: state_next = S_OUT;
                    endcase
                    if (s_req_type == REQ_EDGE && s_node_a != '0 && s_node_b != '0 &&
                        ecnt_reg + LinkW'(2) > LinkW'(Edges))
                        st_next = ST_FULL;
                end
            end
            // store a->b then b->a
            S_E_RD: begin h_ra = a_reg; state_next = S_E_WAIT; end
            S_E_WAIT: state_next = S_E_W1;
            S_E_W1: begin
                e_we = 1'b1; e_wd = {h_rd, b_reg};
                h_we = 1'b1; h_wa = a_reg; h_wd = ecnt_reg + LinkW'(1);
                ecnt_next = ecnt_reg + LinkW'(1);
                built_next = 1'b0;
                if (req_reg == REQ_EDGE) begin
                    a_next = b_reg; b_next = a_reg; req_next = REQ_BUILD;
                    state_next = S_E_RD;
                end else state_next = S_OUT;
            end
            S_E_W2: state_next = S_OUT;
            S_B_CLR: begin
                r_we = 1'b1; r_wa = clr_reg[NodeW-1:0]; r_wd = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (NodeW+1)'(Nodes - 1)) state_next = S_B_INIT;
            end
            S_B_INIT: begin
                built_next = 1'b1;
                if (cfg_root_bad) begin st_next = ST_UNREACHED; state_next = S_OUT; end
                else begin
                    j_next = root_reg; t_next = root_reg; k_next = '0;
                    state_next = S_B_ROOTJ;
                end
            end
            S_B_ROOTJ: begin
                r_we = 1'b1;
                d_we = 1'b1; d_wa = root_reg; d_wd = '0;
                j_we = 1'b1; j_wa = {root_reg, k_reg}; j_wd = root_reg;
                k_next = k_reg + 1'b1;
                if (k_reg == LevelW'(Levels - 1)) begin
                    q_we = 1'b1; q_wa = '0; q_wd = root_reg;
                    qh_next = '0; qt_next = (NodeW+1)'(1);
                    state_next = S_B_POP;
                end
            end
            S_B_POP: begin
                if (qh_reg == qt_reg) state_next = S_OUT;
                else begin q_ra = qh_reg[NodeW-1:0]; state_next = S_B_POPW; end
            end
            S_B_POPW: state_next = S_B_HEAD;
            S_B_HEAD: begin
                t_next = q_rd; qh_next = qh_reg + 1'b1;
                h_ra = q_rd; d_ra = q_rd; state_next = S_B_HEADW;
            end
            S_B_HEADW: begin h_ra = t_reg; d_ra = t_reg; state_next = S_B_LINK; end
            S_B_LINK: begin
                link_next = h_rd; dt_next = d_rd; state_next = S_B_LINKW;
            end
            S_B_LINKW: begin
                if (link_reg == '0 || link_reg > LinkW'(Edges)) state_next = S_B_POP;
                else begin e_ra = EdgeAw'(link_reg - LinkW'(1)); state_next = S_B_CHILD; end
            end
            S_B_CHILD: state_next = S_B_CHILDW;
            S_B_CHILDW: begin
                j_next = e_rd[NodeW-1:0];
                link_next = e_rd[LinkW+NodeW-1:NodeW];
                r_ra = e_rd[NodeW-1:0];
                state_next = S_B_RCHK;
            end
            S_B_RCHK: begin
                if (!r_rd && !qt_reg[NodeW]) begin
                    k_next = '0; state_next = S_B_JREQ;
                end else state_next = S_B_LINKW;
            end
            S_B_JREQ: begin
                r_we = 1'b1;
                d_we = 1'b1; d_wa = j_reg; d_wd = dt_reg + DepthW'(1);
                j_we = 1'b1; j_wa = {j_reg, LevelW'(0)}; j_wd = t_reg;
                p_next = t_reg; k_next = LevelW'(1);
                q_we = 1'b1; q_wa = qt_reg[NodeW-1:0]; q_wd = j_reg;
                qt_next = qt_reg + 1'b1;
                state_next = S_B_JW1;
            end
            // p = up(p, k-1) gives up(j, k)
            S_B_JW1: begin
                if (k_reg == LevelW'(Levels)) state_next = S_B_LINKW;
                else begin j_ra = {p_reg, k_reg - LevelW'(1)}; state_next = S_B_JREQ2; end
            end
            S_B_JREQ2: begin j_ra = {p_reg, k_reg - LevelW'(1)}; state_next = S_B_JWR; end
            S_B_JWR: begin
                j_we = 1'b1; j_wa = {j_reg, k_reg}; j_wd = j_rd;
                p_next = j_rd; k_next = k_reg + 1'b1; state_next = S_B_JW1;
            end
            S_B_JW2: state_next = S_B_JW1;
            S_B_NEXT: state_next = S_B_LINKW;
            S_Q_DEP: begin
                if (!built_reg) begin st_next = ST_UNBUILT; state_next = S_OUT; end
                else if (a_reg == '0 || b_reg == '0) begin
                    st_next = ST_UNREACHED; state_next = S_OUT;
                end else begin r_ra = a_reg; state_next = S_Q_RA; end
            end
            S_Q_RA: begin
                if (!r_rd) begin st_next = ST_UNREACHED; state_next = S_OUT; end
                else begin r_ra = b_reg; state_next = S_Q_RB; end
            end
            S_Q_RB: begin
                if (!r_rd) begin st_next = ST_UNREACHED; state_next = S_OUT; end
                else begin d_ra = a_reg; state_next = S_Q_DEPW; end
            end
            S_Q_DEPW: begin d_ra = b_reg; da_next = d_rd; state_next = S_Q_L1; end
            S_Q_L1: begin
                // deeper one into a
                if (da_reg < d_rd) begin
                    a_next = b_reg; b_next = a_reg; da_next = d_rd; db_next = da_reg;
                end else db_next = d_rd;
                k_next = LevelW'(Levels - 1);
                state_next = S_Q_L1W;
            end
            S_Q_L1W: begin j_ra = {a_reg, k_reg}; state_next = S_Q_L1D; end
            S_Q_L1D: state_next = S_Q_L1DW;
            S_Q_L1DW: begin p_next = j_rd; d_ra = j_rd; state_next = S_Q_L1C; end
            S_Q_L1C: begin d_ra = p_reg; state_next = S_Q_L2A; end
            S_Q_L2A: begin
                if (d_rd >= db_reg) a_next = p_reg;
                if (k_reg == '0) begin
                    k_next = LevelW'(Levels - 1);
                    state_next = S_Q_L2AW;
                end else begin k_next = k_reg - 1'b1; state_next = S_Q_L1W; end
            end
            S_Q_L2AW: begin
                if (a_reg == b_reg) begin anc_next = a_reg; state_next = S_OUT; end
                else begin j_ra = {a_reg, k_reg}; state_next = S_Q_L2B; end
            end
            S_Q_L2B: begin p_next = j_rd; j_ra = {b_reg, k_reg}; state_next = S_Q_L2BW; end
            S_Q_L2BW: begin j_ra = {b_reg, k_reg}; state_next = S_Q_FIN; end
            S_Q_FIN: begin
                if (p_reg != j_rd) begin a_next = p_reg; b_next = j_rd; end
                if (k_reg == '0) begin
                    k_next = '0; state_next = S_Q_FINW;
                end else begin k_next = k_reg - 1'b1; state_next = S_Q_L2AW; end
            end
            S_Q_FINW: begin
                j_ra = {a_reg, LevelW'(0)};
                if (req_reg == REQ_QUERY) begin req_next = REQ_EDGE; end
                else begin anc_next = j_rd; state_next = S_OUT; end
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = (state_reg == S_OUT);
    assign m_ancestor = anc_reg;
    assign m_status = st_reg;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ancestor) && $stable(m_status))
        else $error("result dropped");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        ecnt_reg <= LinkW'(Edges)) else $error("edge count overflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> ecnt_reg + LinkW'(2) > LinkW'(Edges))
        else $error("bad full flag");
endmodule
`default_nettype wire
